### design/hprt_pkg.sv
// Shared types, constants and command codes of the POC reference tracker.
package hprt_pkg;

   localparam int TableCapacityDefault = 8192;
   localparam int EvictCountDefault    = 4096;
   localparam int FarLimitDefault      = 16;

   localparam int PocWidth   = 32;
   localparam int LsbWidth   = 16;
   localparam int DeltaWidth = 16;
   localparam int CfgWidth   = 5;
   localparam int ReqDataW   = 40;
   localparam int ReqUserW   = 3;
   localparam int RspDataW   = 168;
   localparam int RspUserW   = 2;

   localparam logic [CfgWidth-1:0] LogLsbReset = 5'd8;
   localparam logic [CfgWidth-1:0] LogLsbMin   = 5'd4;
   localparam logic [CfgWidth-1:0] LogLsbMax   = 5'd16;

   localparam logic [2:0] CMD_SLICE_START = 3'd0;
   localparam logic [2:0] CMD_REF_DELTA   = 3'd1;
   localparam logic [2:0] CMD_SLICE_END   = 3'd2;
   localparam logic [2:0] CMD_COMMIT      = 3'd3;
   localparam logic [2:0] CMD_CLEAR       = 3'd4;

   localparam logic [1:0] KIND_POC     = 2'd0;
   localparam logic [1:0] KIND_REF     = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   typedef struct packed {
      logic                start;
      logic                insert;
      logic                clear;
      logic [PocWidth-1:0] poc;
   } tbl_req_type;

   typedef struct packed {
      logic done;
      logic found;
   } tbl_rsp_type;

endpackage

### design/hprt_table.sv
// Sorted table of decoded POCs in a ring memory: binary search, insertion, eviction.
module hprt_table #(
   parameter int TABLE_CAPACITY = hprt_pkg::TableCapacityDefault,
   parameter int EVICT_COUNT    = hprt_pkg::EvictCountDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hprt_pkg::tbl_req_type tbl_req,
   output hprt_pkg::tbl_rsp_type tbl_rsp
);
   import hprt_pkg::*;

   localparam int AW    = $clog2(TABLE_CAPACITY + 1);
   localparam int DEPTH = 1 << AW;
   localparam int CW    = $clog2(TABLE_CAPACITY + 2);
   localparam logic [AW-1:0] EvictStep = AW'(EVICT_COUNT % DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_PROBE, S_CMP, S_SHIFT_RD, S_SHIFT_WR, S_PLACE
   } state_type;

   state_type           state_ff;
   logic [CW-1:0]       count_ff, lo_ff, hi_ff, mid_ff, idx_ff;
   logic [AW-1:0]       head_ff;
   logic                found_ff, insert_ff, done_ff;
   logic [PocWidth-1:0] key_ff;

   logic [PocWidth-1:0] mem [DEPTH];
   logic [PocWidth-1:0] rd_data_ff;
   logic [AW-1:0]       rd_addr, wr_addr;
   logic                wr_en;
   logic [PocWidth-1:0] wr_data;
   logic [CW-1:0]       mid, new_count;

   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign new_count = count_ff + CW'(1);

   // During the shift, reads and writes never hit the same entry in one cycle: shift reads j, writes j+1.
   always_comb begin
      rd_addr = head_ff + (state_ff == S_PROBE ? mid[AW-1:0] : idx_ff[AW-1:0]);
      wr_en   = 1'b0;
      wr_addr = head_ff + lo_ff[AW-1:0];
      wr_data = key_ff;
      unique case (state_ff)
         S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = head_ff + idx_ff[AW-1:0] + AW'(1);
            wr_data = rd_data_ff;
         end
         S_PLACE: wr_en = 1'b1;
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         head_ff   <= '0;
         done_ff   <= 1'b0;
         found_ff  <= 1'b0;
         insert_ff <= 1'b0;
         lo_ff     <= '0;
         hi_ff     <= '0;
         mid_ff    <= '0;
         idx_ff    <= '0;
         key_ff    <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (tbl_req.clear) begin
                  count_ff <= '0;
                  head_ff  <= '0;
               end else if (tbl_req.start) begin
                  key_ff    <= tbl_req.poc;
                  insert_ff <= tbl_req.insert;
                  lo_ff     <= '0;
                  hi_ff     <= count_ff;
                  found_ff  <= 1'b0;
                  state_ff  <= S_PROBE;
               end
            end
            S_PROBE: begin
               if (lo_ff < hi_ff) begin
                  mid_ff   <= mid;
                  state_ff <= S_CMP;
               end else if (insert_ff && !found_ff) begin
                  if (count_ff > lo_ff) begin
                     idx_ff   <= count_ff - CW'(1);
                     state_ff <= S_SHIFT_RD;
                  end else begin
                     state_ff <= S_PLACE;
                  end
               end else begin
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_CMP: begin
               // The entry equal to the key, if any, is always probed on the way.
               if ($signed(rd_data_ff) < $signed(key_ff)) lo_ff <= mid_ff + CW'(1);
               else hi_ff <= mid_ff;
               if (rd_data_ff == key_ff) found_ff <= 1'b1;
               state_ff <= S_PROBE;
            end
            S_SHIFT_RD: state_ff <= S_SHIFT_WR;
            S_SHIFT_WR: begin
               if (idx_ff == lo_ff) begin
                  state_ff <= S_PLACE;
               end else begin
                  idx_ff   <= idx_ff - CW'(1);
                  state_ff <= S_SHIFT_RD;
               end
            end
            S_PLACE: begin
               // Drop the smallest entries once the table overflows.
               if (32'(new_count) > TABLE_CAPACITY) begin
                  if (32'(new_count) <= EVICT_COUNT) begin
                     count_ff <= '0;
                     head_ff  <= '0;
                  end else begin
                     count_ff <= new_count - CW'(EVICT_COUNT);
                     head_ff  <= head_ff + EvictStep;
                  end
               end else begin
                  count_ff <= new_count;
               end
               done_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign tbl_rsp.done  = done_ff;
   assign tbl_rsp.found = found_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= TABLE_CAPACITY)
      else $error("table count above capacity");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      tbl_req.start |-> state_ff == S_IDLE)
      else $error("table start while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("table done longer than one cycle");
   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT_WR |-> idx_ff >= lo_ff && idx_ff < count_ff)
      else $error("shift index out of range");

endmodule

### design/hevc_poc_reference_tracker_top.sv
// Top level of the HEVC POC reference tracker: command control, POC derivation, counters.
// Slice start and slice end stage their word in ST_OUT, then move it to the output register
// once that register is free. A used reference delta waits on the binary search over the
// table memory (one read and one compare per step) before its word is staged.
// Commit: search, then a read and write per entry moved by the sorted insertion; one item at a time.
// Reset: synchronous, active high; clears all control state, counters and table count; the
// table memory itself is not cleared (only entries below the count are ever read).
module hevc_poc_reference_tracker_top #(
   parameter int TABLE_CAPACITY = hprt_pkg::TableCapacityDefault,
   parameter int EVICT_COUNT    = hprt_pkg::EvictCountDefault,
   parameter int FAR_LIMIT      = hprt_pkg::FarLimitDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // is_idr[0], poc_lsb[16:1], ref_delta[32:17], ref_used[33], zero pad [39:34]
   input  logic [hprt_pkg::ReqDataW-1:0] req_tdata,
   // cmd[2:0]
   input  logic [hprt_pkg::ReqUserW-1:0] req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // current_poc[31:0], ref_poc[63:32], ref_missing[64], any_missing[65],
   // far_distance[81:66], far_flag[82], missing_slices[114:83], far_slices[146:115],
   // max_distance[162:147], zero pad [167:163]
   output logic [hprt_pkg::RspDataW-1:0] rsp_tdata,
   // kind[1:0]
   output logic [hprt_pkg::RspUserW-1:0] rsp_tuser,
   input  logic                          csr_wen,
   input  logic [hprt_pkg::CfgWidth-1:0] csr_wdata
);
   import hprt_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_TABLE, ST_OUT} state_type;

   state_type             state_ff;
   logic [CfgWidth-1:0]   log_lsb_ff;
   logic [PocWidth-1:0]   prev_msb_ff, pending_poc_ff;
   logic [LsbWidth-1:0]   prev_lsb_ff;
   logic                  pending_valid_ff, any_missing_ff;
   logic [DeltaWidth-1:0] slice_far_ff, max_far_ff;
   logic [PocWidth-1:0]   missing_count_ff, far_count_ff;
   logic                  lookup_ff;
   logic [PocWidth-1:0]   ref_poc_ff;
   logic [DeltaWidth-1:0] mag_ff;

   // result staged until the output register frees up
   logic [RspDataW-1:0]   res_data_ff, res_data_in;
   logic [RspUserW-1:0]   res_kind_ff, res_kind_in;
   logic                  rsp_valid_ff;
   logic [RspDataW-1:0]   rsp_data_ff;
   logic [RspUserW-1:0]   rsp_kind_ff;

   tbl_req_type tbl_req;
   tbl_rsp_type tbl_rsp;

   // Unpack the request word.
   logic [2:0]            cmd;
   logic                  is_idr, ref_used;
   logic [LsbWidth-1:0]   poc_lsb;
   logic [DeltaWidth-1:0] ref_delta;
   assign cmd       = req_tuser;
   assign is_idr    = req_tdata[0];
   assign poc_lsb   = req_tdata[16:1];
   assign ref_delta = req_tdata[32:17];
   assign ref_used  = req_tdata[33];

   logic accept;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // POC derivation with the MSB wrap rule.
   logic [CfgWidth-1:0]   log_lsb;
   logic [LsbWidth:0]     max_lsb, half_lsb;
   logic [LsbWidth-1:0]   lsb;
   logic [LsbWidth:0]     lsb_down, lsb_up;
   logic [PocWidth-1:0]   msb_next, poc_next;
   always_comb begin
      if (log_lsb_ff < LogLsbMin) log_lsb = LogLsbMin;
      else if (log_lsb_ff > LogLsbMax) log_lsb = LogLsbMax;
      else log_lsb = log_lsb_ff;
      max_lsb  = (LsbWidth+1)'(1) << log_lsb;
      half_lsb = max_lsb >> 1;
      lsb      = poc_lsb & LsbWidth'(max_lsb - (LsbWidth+1)'(1));
      lsb_down = {1'b0, prev_lsb_ff} - {1'b0, lsb};
      lsb_up   = {1'b0, lsb} - {1'b0, prev_lsb_ff};
      priority if (lsb < prev_lsb_ff && lsb_down >= half_lsb)
         msb_next = prev_msb_ff + PocWidth'(max_lsb);
      else if (lsb > prev_lsb_ff && lsb_up > half_lsb)
         msb_next = prev_msb_ff - PocWidth'(max_lsb);
      else
         msb_next = prev_msb_ff;
      poc_next = msb_next + PocWidth'(lsb);
   end

   // Reference POC and delta magnitude.
   logic [PocWidth-1:0]   ref_poc;
   logic [DeltaWidth-1:0] mag;
   assign ref_poc = pending_poc_ff + PocWidth'($signed(ref_delta));
   assign mag     = ref_delta[DeltaWidth-1] ? (~ref_delta + DeltaWidth'(1)) : ref_delta;

   // Slice summary values.
   logic                  far_flag;
   logic [PocWidth-1:0]   missing_next, far_next;
   logic [DeltaWidth-1:0] max_next;
   assign far_flag     = {1'b0, slice_far_ff} >= (DeltaWidth+1)'(FAR_LIMIT);
   assign missing_next = missing_count_ff + PocWidth'(any_missing_ff);
   assign far_next     = far_count_ff + PocWidth'(far_flag);
   assign max_next     = (slice_far_ff > max_far_ff) ? slice_far_ff : max_far_ff;

   // Build the result word for the command being finished.
   always_comb begin
      res_data_in = '0;
      res_kind_in = KIND_POC;
      if (state_ff == ST_TABLE) begin
         res_kind_in           = KIND_REF;
         res_data_in[31:0]     = pending_poc_ff;
         res_data_in[63:32]    = ref_poc_ff;
         res_data_in[64]       = !tbl_rsp.found;
      end else if (cmd == CMD_SLICE_END) begin
         res_kind_in           = KIND_SUMMARY;
         res_data_in[31:0]     = pending_poc_ff;
         res_data_in[65]       = any_missing_ff;
         res_data_in[81:66]    = slice_far_ff;
         res_data_in[82]       = far_flag;
         res_data_in[114:83]   = missing_next;
         res_data_in[146:115]  = far_next;
         res_data_in[162:147]  = max_next;
      end else begin
         res_kind_in           = KIND_POC;
         res_data_in[31:0]     = is_idr ? '0 : poc_next;
      end
   end

   always_comb begin
      tbl_req.start  = 1'b0;
      tbl_req.insert = 1'b0;
      tbl_req.clear  = 1'b0;
      tbl_req.poc    = pending_poc_ff;
      if (accept) begin
         unique case (cmd)
            CMD_REF_DELTA: begin
               tbl_req.start = ref_used;
               tbl_req.poc   = ref_poc;
            end
            CMD_COMMIT: begin
               tbl_req.start  = pending_valid_ff;
               tbl_req.insert = 1'b1;
            end
            CMD_CLEAR: tbl_req.clear = 1'b1;
            default: tbl_req.start = 1'b0;
         endcase
      end
   end

   hprt_table #(
      .TABLE_CAPACITY(TABLE_CAPACITY),
      .EVICT_COUNT   (EVICT_COUNT)
   ) u_table (
      .clock  (clock),
      .reset  (reset),
      .tbl_req(tbl_req),
      .tbl_rsp(tbl_rsp)
   );

   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         log_lsb_ff       <= LogLsbReset;
         prev_msb_ff      <= '0;
         prev_lsb_ff      <= '0;
         pending_poc_ff   <= '0;
         pending_valid_ff <= 1'b0;
         any_missing_ff   <= 1'b0;
         slice_far_ff     <= '0;
         missing_count_ff <= '0;
         far_count_ff     <= '0;
         max_far_ff       <= '0;
         lookup_ff        <= 1'b0;
         ref_poc_ff       <= '0;
         mag_ff           <= '0;
         res_data_ff      <= '0;
         res_kind_ff      <= KIND_POC;
         rsp_valid_ff     <= 1'b0;
         rsp_data_ff      <= '0;
         rsp_kind_ff      <= KIND_POC;
      end else begin
         if (csr_wen) log_lsb_ff <= csr_wdata;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (cmd)
                     CMD_SLICE_START: begin
                        if (is_idr) begin
                           prev_msb_ff    <= '0;
                           prev_lsb_ff    <= '0;
                           pending_poc_ff <= '0;
                        end else begin
                           prev_msb_ff    <= msb_next;
                           prev_lsb_ff    <= lsb;
                           pending_poc_ff <= poc_next;
                        end
                        pending_valid_ff <= 1'b1;
                        any_missing_ff   <= 1'b0;
                        slice_far_ff     <= '0;
                        res_data_ff      <= res_data_in;
                        res_kind_ff      <= res_kind_in;
                        state_ff         <= ST_OUT;
                     end
                     CMD_REF_DELTA: begin
                        if (ref_used) begin
                           lookup_ff  <= 1'b1;
                           ref_poc_ff <= ref_poc;
                           mag_ff     <= mag;
                           state_ff   <= ST_TABLE;
                        end
                     end
                     CMD_SLICE_END: begin
                        missing_count_ff <= missing_next;
                        far_count_ff     <= far_next;
                        max_far_ff       <= max_next;
                        any_missing_ff   <= 1'b0;
                        slice_far_ff     <= '0;
                        res_data_ff      <= res_data_in;
                        res_kind_ff      <= res_kind_in;
                        state_ff         <= ST_OUT;
                     end
                     CMD_COMMIT: begin
                        if (pending_valid_ff) begin
                           pending_valid_ff <= 1'b0;
                           lookup_ff        <= 1'b0;
                           state_ff         <= ST_TABLE;
                        end
                     end
                     CMD_CLEAR: begin
                        prev_msb_ff      <= '0;
                        prev_lsb_ff      <= '0;
                        pending_poc_ff   <= '0;
                        pending_valid_ff <= 1'b0;
                        any_missing_ff   <= 1'b0;
                        slice_far_ff     <= '0;
                        missing_count_ff <= '0;
                        far_count_ff     <= '0;
                        max_far_ff       <= '0;
                     end
                     default: state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_TABLE: begin
               // Wait for the search or insertion; a lookup then yields a word.
               if (tbl_rsp.done) begin
                  if (lookup_ff) begin
                     if (!tbl_rsp.found) any_missing_ff <= 1'b1;
                     if (mag_ff > slice_far_ff) slice_far_ff <= mag_ff;
                     res_data_ff <= res_data_in;
                     res_kind_ff <= res_kind_in;
                     state_ff    <= ST_OUT;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_OUT: begin
               // Hold the word until the output register can take it.
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_data_ff;
                  rsp_kind_ff  <= res_kind_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      tbl_rsp.done |-> state_ff == ST_TABLE)
      else $error("table finished while not awaited");
   a_out_no_overrun: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT && rsp_valid_ff && !rsp_tready |=> state_ff == ST_OUT)
      else $error("result staged word lost");
   a_commit_clears: assert property (@(posedge clock) disable iff (reset)
      $fell(pending_valid_ff) |-> $past(accept) &&
         ($past(cmd) == CMD_COMMIT || $past(cmd) == CMD_CLEAR))
      else $error("pending POC dropped without commit or clear");
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_kind_ff != 2'd3)
      else $error("undefined result kind");

endmodule
